FILE: hw/rtl/gprm_pkg.sv
// gprm_pkg: shared types, sizes and codes of the position to reference mapper
// no dependencies; imported by the front, back and top level modules
`timescale 1ns / 1ps
package gprm_pkg;

    localparam int WORD_COUNT      = 16384;
    localparam int WORD_BITS       = 64;
    localparam int MAX_CHROMOSOMES = 32;

    localparam int ADDR_W  = $clog2(WORD_COUNT);
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int CHR_W   = $clog2(MAX_CHROMOSOMES);
    localparam int CNT_W   = 6;
    localparam int SLOT_W  = 14;
    localparam int POS_W   = 20;
    localparam int RANK_W  = 21;
    localparam int KIND_W  = 2;
    localparam int PC_W    = $clog2(WORD_BITS + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_LOAD_WORD  = 2'd0;
    localparam logic [1:0] CMD_LOAD_START = 2'd1;
    localparam logic [1:0] CMD_QUERY      = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_WORD,
        OP_LOAD_START,
        OP_QUERY,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [SLOT_W-1:0]    slot;
        logic [WORD_BITS-1:0] word;
        logic [POS_W-1:0]     pos;
    } t_item;

    // queue head as seen by the back part
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [RANK_W-1:0]    prefix;
    } t_entry;

    function automatic logic [PC_W-1:0] pop_count(input logic [WORD_BITS-1:0] v);
        logic [PC_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            n = n + PC_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] b;
        b = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

endpackage

FILE: hw/rtl/gprm_front.sv
// gprm_front: accepts command beats, classifies them and queues them
// depends on gprm_pkg
`timescale 1ns / 1ps
module gprm_front
    import gprm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_command,
    input  logic [SLOT_W-1:0]    i_slot_index,
    input  logic [WORD_BITS-1:0] i_word_value,
    input  logic [POS_W-1:0]     i_position,
    input  logic                 i_pop,
    output logic                 o_busy,
    output t_head                o_head
);

    t_item r_q [QUEUE_DEPTH];
    logic  r_wr_ptr;
    logic  r_rd_ptr;
    logic [1:0] r_cnt;
    logic  push;
    logic  pop;
    t_item in_item;

    always_comb begin
        in_item.slot = i_slot_index;
        in_item.word = i_word_value;
        in_item.pos  = i_position;
        unique case (i_command)
            CMD_LOAD_WORD:  in_item.op = OP_LOAD_WORD;
            CMD_LOAD_START: in_item.op = OP_LOAD_START;
            CMD_QUERY:      in_item.op = OP_QUERY;
            default:        in_item.op = OP_NOP;
        endcase
    end

    assign o_busy = (r_cnt == 2'(QUEUE_DEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QUEUE_DEPTH)) else $error("queue overfilled");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QUEUE_DEPTH) && !pop) |=> (r_cnt == 2'(QUEUE_DEPTH)))
        else $error("full queue lost an entry");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wr_ptr != r_rd_ptr)) else $error("pointer mismatch");
`endif

endmodule

FILE: hw/rtl/gprm_back.sv
// gprm_back: sequencer that executes loads and queries against the word memory
// depends on gprm_pkg; holds the indicator memory and the chromosome start table
`timescale 1ns / 1ps
module gprm_back
    import gprm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CNT_W-1:0]      i_cfg_wdata,
    input  t_head                 i_head,
    output logic                  o_pop,
    output logic                  o_result_valid,
    output logic [KIND_W-1:0]     o_result_kind,
    output logic [CHR_W-1:0]      o_chromosome_index,
    output logic [RANK_W-1:0]     o_reference_position,
    output logic [POS_W-1:0]      o_variant_offset
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_ACK       = 8'b0000_0010,
        S_LW_WR     = 8'b0000_0100,
        S_SCAN      = 8'b0000_1000,
        S_SRCH      = 8'b0001_0000,
        S_START_SUM = 8'b0010_0000,
        S_EMIT      = 8'b0100_0000,
        S_NONE      = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_item  r_item;
    t_entry r_mem [WORD_COUNT];
    t_entry r_rd_data;
    logic [POS_W-1:0]  r_starts [MAX_CHROMOSOMES];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_c;
    logic [CHR_W-1:0]  r_chrom;
    logic [POS_W-1:0]  r_chrom_start;
    logic [ADDR_W-1:0] r_w;
    logic              r_first;
    logic [RANK_W-1:0] r_rank;
    logic [RANK_W-1:0] r_rank_start;
    logic [POS_W-1:0]  r_off;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_entry            mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CNT_W-1:0]  count_eff;
    logic [WORD_BITS-1:0] pc_in;
    logic [PC_W-1:0]   pc_out;
    logic [WORD_BITS-1:0] srch_bits;
    logic [BIT_W-1:0]  pos_b;
    logic [POS_W-1:0]  cur_start;
    logic              scan_more;

    assign pos_b     = r_item.pos[BIT_W-1:0];
    assign cur_start = r_starts[r_c[CHR_W-1:0]];

    // 0 acts as 1, anything above the table size as the table size
    always_comb begin
        if (r_count == '0) begin
            count_eff = CNT_W'(1);
        end else if (r_count > CNT_W'(MAX_CHROMOSOMES)) begin
            count_eff = CNT_W'(MAX_CHROMOSOMES);
        end else begin
            count_eff = r_count;
        end
    end

    assign scan_more = (r_c < count_eff) && (cur_start <= r_item.pos);

    // word under test: first word masked to bits at or below the position
    assign srch_bits = r_first
        ? (r_rd_data.word & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - pos_b)))
        : r_rd_data.word;

    // shared popcount
    always_comb begin
        priority case (1'b1)
            r_state[4]: pc_in = r_rd_data.word & ((WORD_BITS'(1) << pos_b) - WORD_BITS'(1));
            r_state[5]: pc_in = r_rd_data.word &
                ((WORD_BITS'(1) << r_chrom_start[BIT_W-1:0]) - WORD_BITS'(1));
            default:    pc_in = r_rd_data.word;
        endcase
    end
    assign pc_out = pop_count(pc_in);

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = i_head.item.slot[ADDR_W-1:0];
        mem_wdata.word   = i_head.item.word;
        mem_wdata.prefix = '0;
        mem_re    = 1'b0;
        mem_raddr = i_head.item.slot[ADDR_W-1:0] - ADDR_W'(1);
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid && i_head.item.op == OP_LOAD_WORD) begin
                    if (i_head.item.slot == '0) begin
                        mem_we = 1'b1;
                    end else begin
                        mem_re = 1'b1;
                    end
                end
            end
            S_LW_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_item.slot[ADDR_W-1:0];
                mem_wdata.word   = r_item.word;
                mem_wdata.prefix = r_rd_data.prefix + RANK_W'(pc_out);
            end
            S_SCAN: begin
                mem_re    = !scan_more;
                mem_raddr = r_item.pos[POS_W-1:BIT_W];
            end
            S_SRCH: begin
                mem_re    = 1'b1;
                mem_raddr = (srch_bits != '0) ? r_chrom_start[POS_W-1:BIT_W]
                                              : r_w - ADDR_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_head.valid && i_head.item.op == OP_LOAD_START
            && i_head.item.slot < SLOT_W'(MAX_CHROMOSOMES)) begin
            r_starts[i_head.item.slot[CHR_W-1:0]] <= i_head.item.pos;
        end
    end

    assign o_pop = (r_state == S_IDLE);

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_item        <= i_head.item;
                r_c           <= CNT_W'(1);
                r_chrom       <= '0;
                r_chrom_start <= '0;
                r_rank_start  <= '0;
            end
            S_SCAN: begin
                if (scan_more) begin
                    r_chrom       <= r_c[CHR_W-1:0];
                    r_chrom_start <= cur_start;
                    r_c           <= r_c + CNT_W'(1);
                end else begin
                    r_w     <= r_item.pos[POS_W-1:BIT_W];
                    r_first <= 1'b1;
                end
            end
            S_SRCH: begin
                if (r_first) begin
                    r_rank <= r_rd_data.prefix + RANK_W'(pc_out);
                end
                r_first <= 1'b0;
                r_off   <= r_item.pos - {r_w, top_bit(srch_bits)};
                r_w     <= r_w - ADDR_W'(1);
            end
            S_START_SUM: begin
                r_rank_start <= r_rd_data.prefix + RANK_W'(pc_out);
            end
            default: ;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= CNT_W'(1);
            o_result_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            o_result_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        unique case (i_head.item.op)
                            OP_LOAD_WORD:
                                r_state <= (i_head.item.slot == '0) ? S_ACK : S_LW_WR;
                            OP_QUERY: r_state <= S_SCAN;
                            default:  r_state <= S_ACK;
                        endcase
                    end
                end
                S_LW_WR: r_state <= S_ACK;
                S_ACK: begin
                    o_result_valid <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_SCAN: begin
                    if (!scan_more) begin
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (srch_bits != '0) begin
                        r_state <= (r_chrom != '0) ? S_START_SUM : S_EMIT;
                    end else if (r_w == '0) begin
                        r_state <= S_NONE;
                    end
                end
                S_START_SUM: r_state <= S_EMIT;
                S_EMIT: begin
                    o_result_valid <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_NONE: begin
                    o_result_valid <= 1'b1;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        o_result_kind        <= KIND_ACK;
        o_chromosome_index   <= '0;
        o_reference_position <= '0;
        o_variant_offset     <= '0;
        if (r_state == S_EMIT) begin
            o_result_kind        <= KIND_ANSWER;
            o_chromosome_index   <= r_chrom;
            o_reference_position <= r_rank - r_rank_start;
            o_variant_offset     <= r_off;
        end else if (r_state == S_NONE) begin
            o_result_kind <= KIND_NONE;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid) else $error("result strobe held");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_c <= CNT_W'(MAX_CHROMOSOMES))) else $error("scan overrun");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_kind == KIND_NONE) |->
        (o_reference_position == '0 && o_variant_offset == '0 && o_chromosome_index == '0))
        else $error("no-symbol result carries data");
    a_emit_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_valid) |-> (r_state == S_IDLE)) else $error("strobe outside return");
`endif

endmodule

FILE: hw/rtl/graph_position_to_reference_mapper_top.sv
// graph_position_to_reference_mapper_top: top level of the position mapper
// depends on gprm_pkg, gprm_front and gprm_back
`timescale 1ns / 1ps
//
// channel   direction  handshake             payload
// command   in         start & !busy         command, slot_index, word_value, position
// result    out        o_result_valid strobe result_kind, chromosome_index,
//                                            reference_position, variant_offset
// config    in         i_cfg_we              i_cfg_wdata (chromosome count)
//
// loads to a nonzero slot first read the entry below it through the registered memory read
// queries scan the start table, then search words backward from the position,
// and look up the start's rank when the chromosome is not the first;
// the backward word search and the start rank lookup share the one read port
// a 2 beat queue parts the front from the back; busy rises only when it is full
// reset clears control state and sets the chromosome count to 1; memories stay unset
// results come as one cycle strobes; the receiver cannot stall
module graph_position_to_reference_mapper_top
    import gprm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_command,
    input  logic [SLOT_W-1:0]    i_slot_index,
    input  logic [WORD_BITS-1:0] i_word_value,
    input  logic [POS_W-1:0]     i_position,
    input  logic                 i_cfg_we,
    input  logic [CNT_W-1:0]     i_cfg_wdata,
    output logic                 o_result_valid,
    output logic [KIND_W-1:0]    o_result_kind,
    output logic [CHR_W-1:0]     o_chromosome_index,
    output logic [RANK_W-1:0]    o_reference_position,
    output logic [POS_W-1:0]     o_variant_offset
);

    t_head head;
    logic  pop;

    // front: classify and queue beats
    gprm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_command    (i_command),
        .i_slot_index (i_slot_index),
        .i_word_value (i_word_value),
        .i_position   (i_position),
        .i_pop        (pop),
        .o_busy       (busy),
        .o_head       (head)
    );

    // back: memories and the query sequencer
    gprm_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_head               (head),
        .o_pop                (pop),
        .o_result_valid       (o_result_valid),
        .o_result_kind        (o_result_kind),
        .o_chromosome_index   (o_chromosome_index),
        .o_reference_position (o_reference_position),
        .o_variant_offset     (o_variant_offset)
    );

endmodule
